// ===== design/pidl_pkg.sv =====
// shared widths, codes and types of the positional insert/delete list
package pidl_pkg;

  // default list capacity
  localparam int unsigned CAPACITY_DEF = 1024;

  // fixed field widths
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned POS_W   = 11;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned COUNT_W = 11;

  // command codes
  typedef logic [CMD_W-1:0] cmd_t;
  localparam cmd_t CMD_INSERT = 2'd0;
  localparam cmd_t CMD_DELETE = 2'd1;
  localparam cmd_t CMD_GET    = 2'd2;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // shift control broadcast to every cell
  typedef struct packed {
    logic ins;
    logic del;
  } shift_ctrl_t;

endpackage

// ===== design/pidl_if.sv =====
// request and response channel interfaces of the list
interface pidl_req_if
  import pidl_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          command;
  logic [POS_W-1:0]          position;
  logic signed [VALUE_W-1:0] new_value;

  modport source (output valid, command, position, new_value, input ready);
  modport sink   (input valid, command, position, new_value, output ready);
endinterface

interface pidl_rsp_if
  import pidl_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic [STAT_W-1:0]         status;
  logic signed [VALUE_W-1:0] read_value;
  logic [COUNT_W-1:0]        entry_count;

  modport source (output valid, status, read_value, entry_count, input ready);
  modport sink   (input valid, status, read_value, entry_count, output ready);
endinterface

// ===== design/pidl_cell.sv =====
// one list entry cell: shifts with its neighbors and offers its value for reads
module pidl_cell
  import pidl_pkg::*;
#(
  parameter int unsigned IDX_W = 10,
  parameter int unsigned INDEX = 0
) (
  input  logic               clk_i,
  input  shift_ctrl_t        ctrl_i,
  input  logic [IDX_W-1:0]   at_i,
  input  logic [IDX_W-1:0]   rd_at_i,
  input  logic [VALUE_W-1:0] left_i,
  input  logic [VALUE_W-1:0] right_i,
  input  logic [VALUE_W-1:0] new_value_i,
  output logic [VALUE_W-1:0] value_o,
  output logic [VALUE_W-1:0] rd_o
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic [VALUE_W-1:0] value_q, value_d;

  // next value: hold, take from left or right neighbor, or the new item value
  always_comb begin
    value_d = value_q;
    if (ctrl_i.ins) begin
      if (MY_IDX == at_i) begin
        value_d = new_value_i;
      end else if (MY_IDX > at_i) begin
        value_d = left_i;
      end
    end else if (ctrl_i.del) begin
      if (MY_IDX >= at_i) begin
        value_d = right_i;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

  // gated read lane, zero unless this cell is addressed
  assign rd_o = (MY_IDX == rd_at_i) ? value_q : '0;

endmodule

// ===== design/pidl_read_tree.sv =====
// two-level or-tree that collects the addressed cell value, first level registered
module pidl_read_tree
  import pidl_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic               clk_i,
  input  logic [VALUE_W-1:0] lane_i [CAPACITY],
  output logic [VALUE_W-1:0] value_o
);

  localparam int unsigned IDX_W      = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int unsigned GROUP_SIZE = 1 << ((IDX_W + 1) / 2);
  localparam int unsigned NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

  logic [VALUE_W-1:0] group_q [NUM_GROUPS];
  logic [VALUE_W-1:0] group_d [NUM_GROUPS];

  // first level: or within each group of lanes
  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      group_d[g] = '0;
      for (int l = 0; l < GROUP_SIZE; l++) begin
        if (g * GROUP_SIZE + l < CAPACITY) begin
          group_d[g] = group_d[g] | lane_i[g * GROUP_SIZE + l];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    group_q <= group_d;
  end

  // second level: or across the registered groups
  always_comb begin
    value_o = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      value_o = value_o | group_q[g];
    end
  end

endmodule

// ===== design/positional_insert_delete_list.sv =====
// top level of the positional insert/delete list
//
// Keeps an ordered list of up to CAPACITY signed 32-bit entries in a row of
// cells, one entry per cell. Requests arrive on req_i (command, 1-based
// position, new_value); one response per request leaves on rsp_o (status,
// read_value, entry_count).
// Insert, delete and every rejected request finish at the accepting edge:
// an accepted insert or delete shifts the cells from its position onward by
// one place and the response is registered at that same edge, so it is
// valid in the next cycle. In a successful get the position is latched,
// the cells' gated values pass a registered first level of an or-tree over
// sqrt(CAPACITY) groups, and the second level loads the free response register.
// A new request is taken while the response register is empty or being
// popped in the same cycle; during a get no request is taken.
// If the receiver stalls, the response holds and one more request is not
// taken until it leaves.
// Reset clears the entry count and the response valid; cell contents are
// undefined until written and are never read before that.
module positional_insert_delete_list
  import pidl_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pidl_req_if.sink    req_i,
  pidl_rsp_if.source  rsp_o
);

  localparam int unsigned IDX_W = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD_GROUP,
    S_RD_OUT
  } state_e;

  state_e                    state_q;
  logic [CNT_W-1:0]          count_q;
  logic [IDX_W-1:0]          rd_at_q;
  logic                      rsp_valid_q;
  status_e                   status_q;
  logic signed [VALUE_W-1:0] read_value_q;

  logic                      accept;
  logic                      out_free;
  logic                      rsp_load;
  logic [CMP_W-1:0]          pos_ext, cnt_ext;
  logic                      ins_pos_ok, acc_pos_ok, full;
  logic [IDX_W-1:0]          at;
  shift_ctrl_t               ctrl;
  logic                      get_ok;
  status_e                   status_d;
  logic [VALUE_W-1:0]        cell_val [CAPACITY];
  logic [VALUE_W-1:0]        cell_rd  [CAPACITY];
  logic [VALUE_W-1:0]        tree_val;

  // handshake
  assign out_free    = !rsp_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == S_IDLE) && out_free;
  assign accept      = req_i.valid && req_i.ready;

  // response register loads on a finished request or at the end of a get
  assign rsp_load = (accept && !get_ok) || ((state_q == S_RD_OUT) && out_free);

  // position checks against the current count
  assign pos_ext    = CMP_W'(req_i.position);
  assign cnt_ext    = CMP_W'(count_q);
  assign ins_pos_ok = (pos_ext != '0) && (pos_ext <= cnt_ext + CMP_W'(1));
  assign acc_pos_ok = (pos_ext != '0) && (pos_ext <= cnt_ext);
  assign full       = (cnt_ext == CMP_W'(CAPACITY));
  assign at         = IDX_W'(req_i.position - POS_W'(1));

  // decode the request into shift controls and a status
  always_comb begin
    ctrl     = '0;
    get_ok   = 1'b0;
    status_d = ST_RANGE;
    case (req_i.command)
      CMD_INSERT: begin
        if (!ins_pos_ok) begin
          status_d = ST_RANGE;
        end else if (full) begin
          status_d = ST_FULL;
        end else begin
          status_d = ST_OK;
          ctrl.ins = accept;
        end
      end
      CMD_DELETE: begin
        if (acc_pos_ok) begin
          status_d = ST_OK;
          ctrl.del = accept;
        end
      end
      CMD_GET: begin
        if (acc_pos_ok) begin
          status_d = ST_OK;
          get_ok   = 1'b1;
        end
      end
      default: begin
        status_d = ST_RANGE;
      end
    endcase
  end

  // row of entry cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_W-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_left
      assign left = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_right
      assign right = cell_val[i+1];
    end
    pidl_cell #(
      .IDX_W (IDX_W),
      .INDEX (i)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .at_i        (at),
      .rd_at_i     (rd_at_q),
      .left_i      (left),
      .right_i     (right),
      .new_value_i (req_i.new_value),
      .value_o     (cell_val[i]),
      .rd_o        (cell_rd[i])
    );
  end

  // read collection tree
  pidl_read_tree #(
    .CAPACITY (CAPACITY)
  ) u_read_tree (
    .clk_i   (clk_i),
    .lane_i  (cell_rd),
    .value_o (tree_val)
  );

  // control state, count and response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      rd_at_q      <= '0;
      rsp_valid_q  <= 1'b0;
      status_q     <= ST_OK;
      read_value_q <= '0;
    end else begin
      if (rsp_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_valid_q && rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (ctrl.ins) begin
              count_q <= count_q + CNT_W'(1);
            end else if (ctrl.del) begin
              count_q <= count_q - CNT_W'(1);
            end
            if (get_ok) begin
              rd_at_q <= at;
              state_q <= S_RD_GROUP;
            end else begin
              status_q     <= status_d;
              read_value_q <= '0;
            end
          end
        end
        S_RD_GROUP: begin
          state_q <= S_RD_OUT;
        end
        S_RD_OUT: begin
          if (out_free) begin
            status_q     <= ST_OK;
            read_value_q <= tree_val;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = status_q;
  assign rsp_o.read_value  = read_value_q;
  assign rsp_o.entry_count = COUNT_W'(count_q);

  // the count never passes the capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMP_W'(count_q) <= CMP_W'(CAPACITY))
    else $error("entry count above capacity");

  // no request is taken while a get is in flight
  a_busy_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !req_i.ready)
    else $error("request taken during a get");

  // a successful insert grows the count by one
  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.ins |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("insert did not grow the count");

  // an error response carries a zero value
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && (status_q != ST_OK)) |-> (read_value_q == '0))
    else $error("error response with nonzero value");

endmodule
